[rtl/binary_heap_priority_queue_assert.svh]
// Assertion macros for the priority queue; clocked on clk_i, disabled in reset.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
`define BHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BHPQ_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define BHPQ_ASSERT(lbl, prop, msg)
`define BHPQ_NEVER(lbl, expr, msg)
`endif

`endif

[rtl/bhpq_pkg.sv]
`default_nettype none

package bhpq_pkg;

  typedef struct packed {
    logic [31:0]        tag;
    logic signed [31:0] key;
  } entry_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               top_valid;
    logic signed [31:0] top_key;
    logic [31:0]        top_tag;
    logic [6:0]         fill_count;
    status_e            status;
  } res_t;

  // a strictly better than b under the selected order
  function automatic logic better(input logic signed [31:0] a,
                                  input logic signed [31:0] b,
                                  input logic max_on_top);
    better = max_on_top ? (a > b) : (a < b);
  endfunction

endpackage

`default_nettype wire

[rtl/bhpq_mem.sv]
`default_nettype none

module bhpq_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire bhpq_pkg::entry_t  wdata_i,
  input  wire logic [AW-1:0]     raddr_a_i,
  input  wire logic [AW-1:0]     raddr_b_i,
  output bhpq_pkg::entry_t       rdata_a_o,
  output bhpq_pkg::entry_t       rdata_b_o
);

  bhpq_pkg::entry_t mem_q [DEPTH];
  bhpq_pkg::entry_t rdata_a_q;
  bhpq_pkg::entry_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

[rtl/bhpq_ctrl.sv]
`default_nettype none

module bhpq_ctrl #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned AW       = 6,
  parameter int unsigned CW       = 7
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              in_kind_i,
  input  wire bhpq_pkg::entry_t  in_entry_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output bhpq_pkg::res_t         res_o,
  output logic                   mem_we_o,
  output logic [AW-1:0]          mem_waddr_o,
  output bhpq_pkg::entry_t       mem_wdata_o,
  output logic [AW-1:0]          mem_raddr_a_o,
  output logic [AW-1:0]          mem_raddr_b_o,
  input  wire bhpq_pkg::entry_t  mem_rdata_a_i,
  input  wire bhpq_pkg::entry_t  mem_rdata_b_i
);

  localparam int unsigned IW = AW + 1;

  bhpq_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     pos_q, pos_d;
  bhpq_pkg::entry_t  mov_q, mov_d;
  bhpq_pkg::entry_t  top_q;
  bhpq_pkg::status_e status_q, status_d;
  logic              max_q;

  logic [AW-1:0] parent;
  logic [IW-1:0] child_l, child_r, count_w;
  logic          use_r;
  bhpq_pkg::entry_t pick;

  assign parent  = AW'(pos_q - 1'b1) >> 1;
  assign child_l = {pos_q, 1'b1};
  assign child_r = child_l + 1'b1;
  assign count_w = IW'(count_q);
  assign use_r   = (child_r < count_w) &&
                   bhpq_pkg::better(mem_rdata_b_i.key, mem_rdata_a_i.key, max_q);
  assign pick    = use_r ? mem_rdata_b_i : mem_rdata_a_i;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    pos_d         = pos_q;
    mov_d         = mov_q;
    status_d      = status_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = pos_q;
    mem_wdata_o   = mov_q;
    mem_raddr_a_o = parent;
    mem_raddr_b_o = child_r[AW-1:0];
    in_ready_o    = 1'b0;
    res_valid_o   = 1'b0;
    unique case (state_q)
      bhpq_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        mem_raddr_a_o = AW'(count_q - 1'b1);
        if (in_valid_i) begin
          status_d = bhpq_pkg::ST_DONE;
          mov_d    = in_entry_i;
          if (in_kind_i == bhpq_pkg::KIND_INSERT) begin
            if (count_q == CW'(CAPACITY)) begin
              status_d = bhpq_pkg::ST_FULL;
              state_d  = bhpq_pkg::S_DONE;
            end else begin
              pos_d   = AW'(count_q);
              count_d = count_q + 1'b1;
              state_d = bhpq_pkg::S_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              status_d = bhpq_pkg::ST_EMPTY;
              state_d  = bhpq_pkg::S_DONE;
            end else begin
              count_d = count_q - 1'b1;
              state_d = bhpq_pkg::S_DN_LOAD;
            end
          end
        end
      end
      bhpq_pkg::S_UP_RD: begin
        if (pos_q == '0) begin
          mem_we_o = 1'b1;
          state_d  = bhpq_pkg::S_DONE;
        end else begin
          state_d = bhpq_pkg::S_UP_CMP;
        end
      end
      bhpq_pkg::S_UP_CMP: begin
        mem_we_o = 1'b1;
        if (!bhpq_pkg::better(mov_q.key, mem_rdata_a_i.key, max_q)) begin
          state_d = bhpq_pkg::S_DONE;
        end else begin
          mem_wdata_o = mem_rdata_a_i;
          pos_d       = parent;
          state_d     = bhpq_pkg::S_UP_RD;
        end
      end
      bhpq_pkg::S_DN_LOAD: begin
        mov_d = mem_rdata_a_i;
        pos_d = '0;
        state_d = (count_q == '0) ? bhpq_pkg::S_DONE : bhpq_pkg::S_DN_RD;
      end
      bhpq_pkg::S_DN_RD: begin
        mem_raddr_a_o = child_l[AW-1:0];
        if (child_l >= count_w) begin
          mem_we_o = 1'b1;
          state_d  = bhpq_pkg::S_DONE;
        end else begin
          state_d = bhpq_pkg::S_DN_CMP;
        end
      end
      bhpq_pkg::S_DN_CMP: begin
        mem_we_o = 1'b1;
        if (!bhpq_pkg::better(pick.key, mov_q.key, max_q)) begin
          state_d = bhpq_pkg::S_DONE;
        end else begin
          mem_wdata_o = pick;
          pos_d       = use_r ? child_r[AW-1:0] : child_l[AW-1:0];
          state_d     = bhpq_pkg::S_DN_RD;
        end
      end
      bhpq_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = bhpq_pkg::S_IDLE;
        end
      end
      default: state_d = bhpq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bhpq_pkg::S_IDLE;
      count_q  <= '0;
      status_q <= bhpq_pkg::ST_DONE;
      max_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      status_q <= status_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  // shadow the root so the top is known without another read
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    mov_q <= mov_d;
    if (mem_we_o && mem_waddr_o == '0) begin
      top_q <= mem_wdata_o;
    end
  end

  always_comb begin
    res_o.top_valid  = (count_q != '0);
    res_o.top_key    = res_o.top_valid ? top_q.key : '0;
    res_o.top_tag    = res_o.top_valid ? top_q.tag : '0;
    res_o.fill_count = 7'(count_q);
    res_o.status     = status_q;
  end

endmodule

`default_nettype wire

[rtl/binary_heap_priority_queue.sv]
// Binary heap priority queue of (key, tag) pairs held in on-chip memory.
// Slave stream: tuser selects insert (0) or remove of the top (1); tdata
// carries key and tag. Master stream: one transaction per accepted input,
// giving top validity, top key, top tag, fill count and status.
// cfg_we_i with cfg_wdata_i selects max-heap (1) or min-heap (0); write
// only while idle. Changing it does not reorder held entries.
// An insert moves its entry up until a compare stops it or it reaches the
// root; a remove moves the last entry down from the root until a compare
// stops it or it reaches a leaf, and a remove that empties the heap skips
// that walk. At most log2(CAPACITY) levels are moved. Each level takes a
// memory read and then a compare-and-write on the single write port.
// Full and empty rejections go straight to the result. One item is
// worked on at a time; the next is taken from the cycle after its result
// moves to the output register.
// The result sits in an output register, so the next transaction is taken
// while it waits; a stalled receiver holds back only the following result.
// Reset empties the heap and selects min-heap; memory contents are not
// cleared since slots at or above the fill count are never used.
`default_nettype none

`include "binary_heap_priority_queue_assert.svh"

module binary_heap_priority_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,  // key[31:0], data_tag[63:32]
  input  wire logic        s_axis_tuser_i,  // kind[0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [71:0]      m_axis_tdata_o,  // top_key[31:0], top_tag[63:32],
                                            // fill_count[70:64], zero[71]
  output logic [2:0]       m_axis_tuser_o   // top_valid[0], status[2:1]
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  bhpq_pkg::entry_t in_entry;
  bhpq_pkg::entry_t mem_wdata, mem_rdata_a, mem_rdata_b;
  logic [AW-1:0]    mem_waddr, mem_raddr_a, mem_raddr_b;
  logic             mem_we;
  logic             res_valid, res_ready;
  bhpq_pkg::res_t   res;
  bhpq_pkg::res_t   out_q;
  logic             out_valid_q;

  assign in_entry.key = $signed(s_axis_tdata_i[31:0]);
  assign in_entry.tag = s_axis_tdata_i[63:32];

  bhpq_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_kind_i     (s_axis_tuser_i),
    .in_entry_i    (in_entry),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  bhpq_mem #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.fill_count, out_q.top_tag, out_q.top_key};
  assign m_axis_tuser_o  = {out_q.status, out_q.top_valid};

  `BHPQ_NEVER(a_busy_excl, res_valid && s_axis_tready_o, "input taken with result pending")
  `BHPQ_ASSERT(a_out_load, res_valid && res_ready |=> m_axis_tvalid_o, "result dropped")
  `BHPQ_ASSERT(a_waddr_rng, mem_we |-> (32'(mem_waddr) < CAPACITY), "write beyond capacity")
  `BHPQ_NEVER(a_empty_top, res_valid && res.status == bhpq_pkg::ST_EMPTY && res.top_valid, "empty remove shows a top")

endmodule

`default_nettype wire

[verif/tb_binary_heap_priority_queue.sv]
`timescale 1ns / 100ps

module tb_binary_heap_priority_queue;

  localparam int unsigned CAPACITY   = 64;
  localparam bit          ORDER_MIN  = 1'b0;
  localparam bit          ORDER_MAX  = 1'b1;
  localparam int unsigned SETTLE_CYC = 24;
  localparam int unsigned HOLD_CYC   = 400;

  class heap_scoreboard;
    logic signed [31:0]    keys[CAPACITY];
    logic [31:0]           tags[CAPACITY];
    int unsigned           count;
    bit                    max_on_top;
    bhpq_pkg::res_t        expected_q[$];
    int unsigned           errors;

    function new();
      count      = 0;
      max_on_top = ORDER_MIN;
      errors     = 0;
    endfunction

    function bit outranks(logic signed [31:0] a, logic signed [31:0] b);
      return max_on_top ? (a > b) : (a < b);
    endfunction

    function void set_order(bit order);
      max_on_top = order;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(bhpq_pkg::kind_e kind, logic signed [31:0] key,
                             logic [31:0] tag);
      bhpq_pkg::res_t     r;
      int unsigned        pos;
      int unsigned        par;
      int unsigned        ch;
      logic signed [31:0] k;
      logic [31:0]        t;
      r.status = bhpq_pkg::ST_DONE;
      if (kind == bhpq_pkg::KIND_INSERT) begin
        if (count >= CAPACITY) begin
          r.status = bhpq_pkg::ST_FULL;
        end else begin
          pos = count;
          while (pos > 0) begin
            par = (pos - 1) / 2;
            if (!outranks(key, keys[par])) break;
            keys[pos] = keys[par];
            tags[pos] = tags[par];
            pos = par;
          end
          keys[pos] = key;
          tags[pos] = tag;
          count++;
        end
      end else begin
        if (count == 0) begin
          r.status = bhpq_pkg::ST_EMPTY;
        end else begin
          count--;
          k   = keys[count];
          t   = tags[count];
          pos = 0;
          ch  = 1;
          while (ch < count) begin
            if (ch + 1 < count && outranks(keys[ch + 1], keys[ch])) ch++;
            if (!outranks(keys[ch], k)) break;
            keys[pos] = keys[ch];
            tags[pos] = tags[ch];
            pos = ch;
            ch  = pos * 2 + 1;
          end
          keys[pos] = k;
          tags[pos] = t;
        end
      end
      r.top_valid  = (count > 0);
      r.top_key    = (count > 0) ? keys[0] : '0;
      r.top_tag    = (count > 0) ? tags[0] : '0;
      r.fill_count = count[6:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [71:0] data, logic [2:0] user);
      bhpq_pkg::res_t r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: top_key %0d fill_count %0d", $signed(data[31:0]),
               data[70:64]);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (user[0] !== r.top_valid) begin
        $error("top_valid: expected %0d, actual %0d", r.top_valid, user[0]);
        errors++;
      end
      if (data[31:0] !== r.top_key) begin
        $error("top_key: expected %0d, actual %0d", r.top_key, $signed(data[31:0]));
        errors++;
      end
      if (data[63:32] !== r.top_tag) begin
        $error("top_tag: expected %08h, actual %08h", r.top_tag, data[63:32]);
        errors++;
      end
      if (data[70:64] !== r.fill_count) begin
        $error("fill_count: expected %0d, actual %0d", r.fill_count, data[70:64]);
        errors++;
      end
      if (user[2:1] !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, user[2:1]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [71:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  heap_scoreboard heap_sb;
  bit             tx_quiet;
  int unsigned    rx_count;

  binary_heap_priority_queue #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("FAIL binary_heap_priority_queue");
    $finish;
  end

  // note each accepted input transaction, check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      heap_sb.note_input(bhpq_pkg::kind_e'(s_axis_tuser_i), s_axis_tdata_i[31:0],
                         s_axis_tdata_i[63:32]);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      heap_sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  task automatic send_item(bhpq_pkg::kind_e kind, logic [31:0] key, logic [31:0] tag);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {tag, key};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (heap_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_order(bit order);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= order;
    heap_sb.set_order(order);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return $urandom_range(0, 8) - 4;
    if (sel == 3) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  task automatic run_phase(bit order, int unsigned insert_pct, int unsigned n, bit quiet);
    write_order(order);
    tx_quiet = quiet;
    repeat (n) begin
      if ($urandom_range(0, 99) < insert_pct) begin
        send_item(bhpq_pkg::KIND_INSERT, pick_key(), $urandom);
      end else begin
        send_item(bhpq_pkg::KIND_REMOVE, $urandom, $urandom);
      end
    end
  endtask

  // receiver: random stalls, quiet stretches and one long hold-off
  initial begin
    int unsigned stall;
    m_axis_tready_i = 1'b0;
    rx_count        = 0;
    @(posedge rst_ni);
    forever begin
      if (rx_count == 200) stall = HOLD_CYC;
      else if ((rx_count / 50) % 3 == 2) stall = 0;
      else stall = $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      rx_count++;
    end
  end

  initial begin
    heap_sb         = new();
    tx_quiet        = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = bhpq_pkg::KIND_INSERT;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_order(ORDER_MIN);
    send_item(bhpq_pkg::KIND_REMOVE, 32'h0, 32'h0);
    send_item(bhpq_pkg::KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_item(bhpq_pkg::KIND_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
    send_item(bhpq_pkg::KIND_INSERT, 32'h8000_0000, 32'h0000_0001);
    send_item(bhpq_pkg::KIND_INSERT, 32'hffff_ffff, 32'h0000_0002);
    send_item(bhpq_pkg::KIND_INSERT, 32'h0000_0005, 32'h0000_000a);
    send_item(bhpq_pkg::KIND_INSERT, 32'h0000_0005, 32'h0000_000b);
    send_item(bhpq_pkg::KIND_INSERT, 32'h0000_0005, 32'h0000_000c);
    send_item(bhpq_pkg::KIND_REMOVE, 32'hffff_ffff, 32'hffff_ffff);
    send_item(bhpq_pkg::KIND_REMOVE, 32'h0, 32'h0);
    send_item(bhpq_pkg::KIND_REMOVE, 32'h0, 32'h0);
    // flip the order with entries held
    write_order(ORDER_MAX);
    send_item(bhpq_pkg::KIND_INSERT, 32'h0000_0005, 32'h0000_000d);
    send_item(bhpq_pkg::KIND_INSERT, 32'h7fff_ffff, 32'h5555_5555);
    send_item(bhpq_pkg::KIND_INSERT, 32'h8000_0000, 32'haaaa_aaaa);
    repeat (8) send_item(bhpq_pkg::KIND_REMOVE, 32'h0, 32'h0);
    send_item(bhpq_pkg::KIND_REMOVE, 32'h0, 32'h0);

    run_phase(ORDER_MIN, 90, 120, 1'b0);
    run_phase(ORDER_MIN, 20, 120, 1'b1);
    run_phase(ORDER_MAX, 75, 150, 1'b0);
    run_phase(ORDER_MIN, 50, 150, 1'b0);
    run_phase(ORDER_MAX, 90, 120, 1'b1);
    run_phase(ORDER_MAX, 15, 120, 1'b0);
    run_phase(ORDER_MIN, 60, 120, 1'b0);

    drain();
    if (heap_sb.errors == 0) begin
      $display("PASS binary_heap_priority_queue");
    end else begin
      $display("FAIL binary_heap_priority_queue");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/bhpq_pkg.sv
rtl/bhpq_mem.sv
rtl/bhpq_ctrl.sv
rtl/binary_heap_priority_queue.sv
verif/tb_binary_heap_priority_queue.sv
